// ===== rtl/sisu_pkg.sv =====
package sisu_pkg;

   localparam int KEY_FIELD_BITS = 16;
   localparam int POS_BITS       = 9;
   localparam int GROUP_CELLS    = 16;
   localparam int GROUP_IDX_BITS = 4;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_DELETE = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_REMOVED  = 3'd2,
      ST_MISSING  = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COMPARE,
      S_GROUP,
      S_LOCATE,
      S_APPLY
   } state_type;

   typedef struct packed {
      kind_type                  kind;
      logic [KEY_FIELD_BITS-1:0] key;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [POS_BITS-1:0] position;
      logic [POS_BITS-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic compare;
      logic shift_ins;
      logic shift_del;
   } cell_ctrl_type;

   typedef struct packed {
      logic                      all_lt;
      logic                      any_eq;
      logic [GROUP_IDX_BITS-1:0] first_ge;
   } group_sum_type;

endpackage

// ===== rtl/sisu_cell.sv =====
module sisu_cell #(
   parameter int KEY_BITS = 16,
   parameter int CW       = 9,
   parameter int INDEX    = 0
) (
   input  logic                   clock,
   input  sisu_pkg::cell_ctrl_type ctrl,
   input  logic [CW-1:0]          count,
   input  logic [KEY_BITS-1:0]    key,
   input  logic [KEY_BITS-1:0]    left_key,
   input  logic                   left_lt,
   input  logic [KEY_BITS-1:0]    right_key,
   output logic [KEY_BITS-1:0]    cell_key,
   output logic                   cell_lt,
   output logic                   cell_eq
);

   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] key_in;
   logic                lt_ff;
   logic                lt_in;
   logic                eq_ff;
   logic                eq_in;
   logic                live;

   always_comb begin
      live  = CW'(INDEX) < count;
      lt_in = live && (key_ff < key);
      eq_in = live && (key_ff == key);
      priority if (ctrl.shift_ins && !lt_ff) begin
         key_in = left_lt ? key : left_key;
      end else if (ctrl.shift_del && !lt_ff) begin
         key_in = right_key;
      end else begin
         key_in = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (ctrl.compare) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
   end

   assign cell_key = key_ff;
   assign cell_lt  = lt_ff;
   assign cell_eq  = eq_ff;

endmodule

// ===== rtl/sisu_group.sv =====
module sisu_group (
   input  logic                                 clock,
   input  logic [sisu_pkg::GROUP_CELLS-1:0]     lt,
   input  logic [sisu_pkg::GROUP_CELLS-1:0]     eq,
   output sisu_pkg::group_sum_type              sum
);

   sisu_pkg::group_sum_type sum_ff;
   sisu_pkg::group_sum_type sum_in;

   always_comb begin
      sum_in.all_lt   = &lt;
      sum_in.any_eq   = |eq;
      sum_in.first_ge = '0;
      for (int j = 0; j < sisu_pkg::GROUP_CELLS; j++) begin
         if (!lt[j] && (j == 0 || lt[(j == 0) ? 0 : j - 1])) begin
            sum_in.first_ge = sum_in.first_ge | sisu_pkg::GROUP_IDX_BITS'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;

endmodule

// ===== rtl/sorted_index_set_update.sv =====
// Channel   Ports                         Handshake
// request   start, busy, req_item         taken when start && !busy
// result    rsp_valid, rsp_item           one cycle pulse, no backpressure
//
// Each request steps through: compare in every cell, group reduce,
// locate slot, shift cells, then the result pulse; busy is low again
// in the cycle that shows the result. Reset empties the list at once.
// The receiver cannot stall; a result is shown for exactly one cycle.
module sorted_index_set_update #(
   parameter int DEPTH    = 256,
   parameter int KEY_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sisu_pkg::req_type req_item,
   output logic              rsp_valid,
   output sisu_pkg::rsp_type rsp_item
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int NG = (DEPTH + sisu_pkg::GROUP_CELLS - 1) / sisu_pkg::GROUP_CELLS;
   localparam int NP = NG * sisu_pkg::GROUP_CELLS;

   sisu_pkg::state_type     state_ff;
   sisu_pkg::state_type     state_in;
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;
   logic [KEY_BITS-1:0]     key_ff;
   logic [KEY_BITS-1:0]     key_in;
   sisu_pkg::kind_type      kind_ff;
   sisu_pkg::kind_type      kind_in;
   logic [CW-1:0]           pos_ff;
   logic [CW-1:0]           pos_in;
   logic                    hit_ff;
   logic                    hit_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   sisu_pkg::rsp_type       rsp_ff;
   sisu_pkg::rsp_type       rsp_in;
   sisu_pkg::cell_ctrl_type ctrl;

   logic [KEY_BITS-1:0]     cell_key [DEPTH];
   logic [NP-1:0]           lt_pad;
   logic [NP-1:0]           eq_pad;
   sisu_pkg::group_sum_type group_sum [NG];

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         sisu_cell #(
            .KEY_BITS(KEY_BITS),
            .CW      (CW),
            .INDEX   (i)
         ) u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .count    (count_ff),
            .key      (key_ff),
            .left_key (cell_key[(i == 0) ? 0 : i - 1]),
            .left_lt  ((i == 0) ? 1'b1 : lt_pad[(i == 0) ? 0 : i - 1]),
            .right_key(cell_key[(i == DEPTH - 1) ? i : i + 1]),
            .cell_key (cell_key[i]),
            .cell_lt  (lt_pad[i]),
            .cell_eq  (eq_pad[i])
         );
      end
      if (NP > DEPTH) begin : g_pad
         assign lt_pad[NP-1:DEPTH] = '0;
         assign eq_pad[NP-1:DEPTH] = '0;
      end
      for (i = 0; i < NG; i++) begin : g_group
         sisu_group u_group (
            .clock(clock),
            .lt   (lt_pad[i*sisu_pkg::GROUP_CELLS +: sisu_pkg::GROUP_CELLS]),
            .eq   (eq_pad[i*sisu_pkg::GROUP_CELLS +: sisu_pkg::GROUP_CELLS]),
            .sum  (group_sum[i])
         );
      end
   endgenerate

   always_comb begin
      pos_in = CW'(DEPTH);
      hit_in = 1'b0;
      for (int g = 0; g < NG; g++) begin
         hit_in = hit_in | group_sum[g].any_eq;
         if (!group_sum[g].all_lt && (g == 0 || group_sum[(g == 0) ? 0 : g - 1].all_lt)) begin
            pos_in = CW'(g * sisu_pkg::GROUP_CELLS) | CW'(group_sum[g].first_ge);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      kind_in      = kind_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctrl         = '0;
      unique case (state_ff)
         sisu_pkg::S_IDLE: begin
            if (start) begin
               key_in   = KEY_BITS'(req_item.key);
               kind_in  = req_item.kind;
               state_in = sisu_pkg::S_COMPARE;
            end
         end
         sisu_pkg::S_COMPARE: begin
            ctrl.compare = 1'b1;
            state_in     = sisu_pkg::S_GROUP;
         end
         sisu_pkg::S_GROUP: begin
            state_in = sisu_pkg::S_LOCATE;
         end
         sisu_pkg::S_LOCATE: begin
            state_in = sisu_pkg::S_APPLY;
         end
         sisu_pkg::S_APPLY: begin
            priority if (kind_ff == sisu_pkg::KIND_INSERT && hit_ff) begin
               rsp_in.status = sisu_pkg::ST_PRESENT;
            end else if (kind_ff == sisu_pkg::KIND_INSERT && count_ff == CW'(DEPTH)) begin
               rsp_in.status = sisu_pkg::ST_FULL;
            end else if (kind_ff == sisu_pkg::KIND_INSERT) begin
               rsp_in.status  = sisu_pkg::ST_INSERTED;
               ctrl.shift_ins = 1'b1;
               count_in       = count_ff + CW'(1);
            end else if (hit_ff) begin
               rsp_in.status  = sisu_pkg::ST_REMOVED;
               ctrl.shift_del = 1'b1;
               count_in       = count_ff - CW'(1);
            end else begin
               rsp_in.status = sisu_pkg::ST_MISSING;
            end
            rsp_in.position    = sisu_pkg::POS_BITS'(pos_ff);
            rsp_in.entry_count = sisu_pkg::POS_BITS'(count_in);
            rsp_valid_in       = 1'b1;
            state_in           = sisu_pkg::S_IDLE;
         end
         default: begin
            state_in = sisu_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sisu_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      kind_ff <= kind_in;
      pos_ff  <= pos_in;
      hit_ff  <= hit_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = state_ff != sisu_pkg::S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== rtl/sisu_checker.sv =====
module sisu_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input sisu_pkg::rsp_type rsp_item
);

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after request");

   a_result_latency : assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##5 rsp_valid)
      else $error("result missing five cycles after request");

   a_result_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && !$past(rsp_valid))
      else $error("result while busy or back to back");

   a_insert_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == sisu_pkg::ST_INSERTED |-> rsp_item.entry_count != '0)
      else $error("insert left list empty");

endmodule

bind sorted_index_set_update sisu_checker u_sisu_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp_item (rsp_item)
);

// ===== tb/sorted_index_set_update_tb.sv =====
module sorted_index_set_update_tb;
   import sisu_pkg::*;

   localparam int DEPTH          = 256;
   localparam int KEY_MAX        = 16'hFFFF;
   localparam int IDLE_PERCENT   = 38;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int RANDOM_UPDATES = 900;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   logic [KEY_FIELD_BITS-1:0] held_keys [DEPTH];
   int unsigned               held_count;
   rsp_type                   expected_updates [$];
   int                        error_count;
   int                        stall_cycles;
   bit                        idle_on;

   sorted_index_set_update #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_FIELD_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rsp_type predict_update(req_type r);
      rsp_type     res;
      int unsigned slot;
      bit          hit;
      slot = 0;
      while (slot < held_count && held_keys[slot] < r.key) slot++;
      hit = (slot < held_count) && (held_keys[slot] == r.key);
      if (r.kind == KIND_INSERT) begin
         if (hit) begin
            res.status = ST_PRESENT;
         end else if (held_count >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            for (int i = held_count; i > slot; i--) held_keys[i] = held_keys[i-1];
            held_keys[slot] = r.key;
            held_count++;
            res.status = ST_INSERTED;
         end
      end else begin
         if (hit) begin
            for (int i = slot; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
            held_count--;
            res.status = ST_REMOVED;
         end else begin
            res.status = ST_MISSING;
         end
      end
      res.position    = POS_BITS'(slot);
      res.entry_count = POS_BITS'(held_count);
      return res;
   endfunction

   // call right after a rising edge; returns right after the accepting edge
   task automatic send_request(kind_type kind, logic [KEY_FIELD_BITS-1:0] key);
      req_type r;
      r.kind = kind;
      r.key  = key;
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      expected_updates.push_back(predict_update(r));
   endtask

   function automatic logic [KEY_FIELD_BITS-1:0] pick_key();
      int unsigned choice;
      logic [KEY_FIELD_BITS-1:0] k;
      choice = $urandom_range(99);
      if (held_count > 0 && choice < 40) begin
         k = held_keys[$urandom_range(held_count - 1)];
      end else if (held_count > 0 && choice < 60) begin
         k = KEY_FIELD_BITS'(held_keys[$urandom_range(held_count - 1)]
                             + ($urandom_range(1) ? 1 : -1));
      end else if (choice < 70) begin
         k = KEY_FIELD_BITS'($urandom_range(15));
      end else begin
         k = KEY_FIELD_BITS'($urandom_range(KEY_MAX));
      end
      return k;
   endfunction

   task automatic test_directed();
      send_request(KIND_DELETE, 16'h1234);
      send_request(KIND_INSERT, 16'h8000);
      send_request(KIND_INSERT, 16'h0000);
      send_request(KIND_INSERT, 16'hFFFF);
      send_request(KIND_INSERT, 16'h8000);
      send_request(KIND_INSERT, 16'h7FFF);
      send_request(KIND_INSERT, 16'h8001);
      send_request(KIND_DELETE, 16'h4000);
      send_request(KIND_DELETE, 16'hFFFF);
      send_request(KIND_DELETE, 16'h0000);
      send_request(KIND_DELETE, 16'h8000);
      send_request(KIND_DELETE, 16'h8000);
      send_request(KIND_INSERT, 16'h5555);
      send_request(KIND_INSERT, 16'hAAAA);
      send_request(KIND_INSERT, 16'h0001);
      send_request(KIND_DELETE, 16'h7FFF);
      send_request(KIND_DELETE, 16'h8001);
      send_request(KIND_DELETE, 16'h5555);
      send_request(KIND_DELETE, 16'hAAAA);
      send_request(KIND_DELETE, 16'h0001);
      send_request(KIND_DELETE, 16'hFFFF);
   endtask

   task automatic test_fill_and_drain();
      while (held_count < DEPTH) begin
         if ($urandom_range(9) == 0) begin
            send_request(KIND_INSERT, pick_key());
         end else begin
            send_request(KIND_INSERT, KEY_FIELD_BITS'($urandom_range(KEY_MAX - 1)));
         end
      end
      send_request(KIND_INSERT, 16'hFFFF);
      send_request(KIND_INSERT, 16'h0000);
      repeat (20) send_request(KIND_INSERT, pick_key());
      while (held_count > 0) begin
         if ($urandom_range(3) == 0) begin
            send_request(KIND_DELETE, KEY_FIELD_BITS'($urandom_range(KEY_MAX)));
         end else begin
            send_request(KIND_DELETE, held_keys[$urandom_range(held_count - 1)]);
         end
      end
   endtask

   task automatic test_random_mix();
      for (int n = 0; n < RANDOM_UPDATES; n++) begin
         idle_on = !(n >= 300 && n < 600);
         send_request(kind_type'($urandom_range(1)), pick_key());
      end
      idle_on = 1'b1;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_updates.size() == 0) begin
            $display("%0t: unexpected result status %0d position %0d count %0d", $time,
                     rsp_item.status, rsp_item.position, rsp_item.entry_count);
            error_count++;
         end else begin
            want = expected_updates.pop_front();
            if (rsp_item.status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status,
                        rsp_item.status);
               error_count++;
            end
            if (rsp_item.position !== want.position) begin
               $display("%0t: position expected %0d got %0d", $time, want.position,
                        rsp_item.position);
               error_count++;
            end
            if (rsp_item.entry_count !== want.entry_count) begin
               $display("%0t: entry_count expected %0d got %0d", $time,
                        want.entry_count, rsp_item.entry_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      held_count  = 0;
      error_count = 0;
      idle_on     = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_and_drain();
      test_random_mix();
      start <= 1'b0;
      while (expected_updates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
